FILE: sv/tlfp_pkg.sv
// Shared types and constants for the type-length frame parser.
// No dependencies; every other file of the block imports this package.
package tlfp_pkg;

   // Length field limits.
   localparam int MAX_LENGTH_BYTES = 4;
   localparam int LEN_W            = 28;
   localparam int LCNT_W           = 2;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_W           = 1;
   localparam int QCNT_W           = 2;

   // Configuration register map.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 28'd4194304;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Error codes.
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_ZERO_TYPE = 2'd1;
   localparam logic [1:0] ERR_OVERLONG  = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG  = 2'd3;

   // Parser phases.
   typedef enum logic [1:0] {
      PH_TYPE,
      PH_LENGTH,
      PH_PAYLOAD,
      PH_ERROR
   } phase_type;

   // One received byte.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       resync;
   } req_type;

   // One result.
   typedef struct packed {
      logic [1:0]       result_kind;
      logic [7:0]       frame_type;
      logic [LEN_W-1:0] frame_length;
      logic [7:0]       payload_byte;
      logic [1:0]       error_code;
      logic             frame_end;
   } rsp_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

FILE: sv/tlfp_front.sv
// Front end of the frame parser: tracks the frame phase and classifies each byte.
// Depends on tlfp_pkg; pushes at most one result per accepted byte into the queue.
module tlfp_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  tlfp_pkg::req_type        req_data,
   input  logic [tlfp_pkg::LEN_W-1:0] max_payload_length,
   output logic                     push,
   output tlfp_pkg::rsp_type        push_data
);
   import tlfp_pkg::*;

   phase_type          phase_ff, phase_in, phase_eff;
   logic [7:0]         type_ff, type_in;
   logic [LEN_W-1:0]   acc_ff, acc_in;
   logic [LCNT_W-1:0]  lcnt_ff, lcnt_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;

   logic [LEN_W-1:0]   acc_new;
   logic [LEN_W-1:0]   remain_dec;
   logic [LCNT_W:0]    lcnt_inc;
   logic               more_len;
   logic               overlong;
   logic               too_long;
   logic               zero_len;

   // A resync byte is always treated as a type byte.
   assign phase_eff = req_data.resync ? PH_TYPE : phase_ff;

   // Length digit placed at 7 bits per length byte already seen.
   always_comb begin
      acc_new = acc_ff;
      case (lcnt_ff)
         2'd0:    acc_new = acc_ff | {21'd0, req_data.rx_byte[6:0]};
         2'd1:    acc_new = acc_ff | {14'd0, req_data.rx_byte[6:0], 7'd0};
         2'd2:    acc_new = acc_ff | {7'd0, req_data.rx_byte[6:0], 14'd0};
         default: acc_new = acc_ff | {req_data.rx_byte[6:0], 21'd0};
      endcase
   end

   assign lcnt_inc   = {1'b0, lcnt_ff} + {{LCNT_W{1'b0}}, 1'b1};
   assign more_len   = req_data.rx_byte[7];
   assign overlong   = more_len && (lcnt_inc >= (LCNT_W+1)'(MAX_LENGTH_BYTES));
   assign too_long   = acc_new > max_payload_length;
   assign zero_len   = acc_new == '0;
   assign remain_dec = remain_ff - {{(LEN_W-1){1'b0}}, 1'b1};

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_eff)
            PH_TYPE:
               phase_in = (req_data.rx_byte == 8'h00) ? PH_ERROR : PH_LENGTH;
            PH_LENGTH: begin
               if (more_len) begin
                  phase_in = overlong ? PH_ERROR : PH_LENGTH;
               end else if (too_long) begin
                  phase_in = PH_ERROR;
               end else if (zero_len) begin
                  phase_in = PH_TYPE;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD:
               phase_in = (remain_dec == '0) ? PH_TYPE : PH_PAYLOAD;
            PH_ERROR:
               phase_in = PH_ERROR;
            default:
               phase_in = PH_ERROR;
         endcase
      end
   end

   // Datapath updates and the result pushed for this byte.
   always_comb begin
      type_in   = type_ff;
      acc_in    = acc_ff;
      lcnt_in   = lcnt_ff;
      remain_in = remain_ff;
      push      = 1'b0;
      push_data = '{result_kind: KIND_HEADER, frame_type: type_ff, frame_length: '0,
                    payload_byte: 8'h00, error_code: ERR_NONE, frame_end: 1'b0};
      if (accept) begin
         unique case (phase_eff)
            PH_TYPE: begin
               type_in = req_data.rx_byte;
               acc_in  = '0;
               lcnt_in = '0;
               if (req_data.rx_byte == 8'h00) begin
                  push                   = 1'b1;
                  push_data.result_kind  = KIND_ERROR;
                  push_data.frame_type   = 8'h00;
                  push_data.error_code   = ERR_ZERO_TYPE;
               end
            end
            PH_LENGTH: begin
               acc_in = acc_new;
               if (more_len) begin
                  lcnt_in = lcnt_inc[LCNT_W-1:0];
                  if (overlong) begin
                     lcnt_in                = lcnt_ff;
                     push                   = 1'b1;
                     push_data.result_kind  = KIND_ERROR;
                     push_data.error_code   = ERR_OVERLONG;
                  end
               end else if (too_long) begin
                  push                  = 1'b1;
                  push_data.result_kind = KIND_ERROR;
                  push_data.error_code  = ERR_TOO_LONG;
               end else begin
                  remain_in              = acc_new;
                  push                   = 1'b1;
                  push_data.frame_length = acc_new;
                  push_data.frame_end    = zero_len;
               end
            end
            PH_PAYLOAD: begin
               remain_in              = remain_dec;
               push                   = 1'b1;
               push_data.result_kind  = KIND_PAYLOAD;
               push_data.payload_byte = req_data.rx_byte;
               push_data.frame_end    = remain_dec == '0;
            end
            PH_ERROR: begin
               push = 1'b0;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         type_ff   <= 8'h00;
         acc_ff    <= '0;
         lcnt_ff   <= '0;
         remain_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         type_ff   <= type_in;
         acc_ff    <= acc_in;
         lcnt_ff   <= lcnt_in;
         remain_ff <= remain_in;
      end
   end

endmodule

FILE: sv/tlfp_queue.sv
// Two-entry result queue between the parser front end and the output stage.
// Depends on tlfp_pkg for the result type and the queue status struct.
module tlfp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  tlfp_pkg::rsp_type           push_data,
   input  logic                        pop,
   output tlfp_pkg::rsp_type           head_data,
   output tlfp_pkg::queue_status_type  status
);
   import tlfp_pkg::*;

   rsp_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign status.not_empty = count_ff != '0;
   assign status.full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_data        = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.not_empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/tlfp_back.sv
// Output stage of the frame parser: drains the result queue into the rsp register.
// Depends on tlfp_pkg for the result type and the queue status struct.
module tlfp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  tlfp_pkg::queue_status_type  status,
   input  tlfp_pkg::rsp_type           head_data,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tlfp_pkg::rsp_type           rsp_data
);
   import tlfp_pkg::*;

   logic     valid_ff, valid_in;
   rsp_type  data_ff, data_in;

   // Load the output register whenever it is empty or its beat is taken.
   assign pop      = status.not_empty && (!valid_ff || !rsp_stall);
   assign valid_in = pop ? 1'b1 : (valid_ff && rsp_stall);
   assign data_in  = pop ? head_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: sv/type_length_frame_parser_unit.sv
// Top level of the type-length frame parser: CSR port, front end, queue, output stage.
// Depends on tlfp_pkg, tlfp_front, tlfp_queue and tlfp_back.
//
//   Port group  Direction  Handshake          Beat
//   req_*       in         req_valid/stall    one received byte plus resync flag
//   rsp_*       out        rsp_valid/stall    one header, payload or error result
//   csr_*       in/out     APB write/read     max_payload_length at byte address 0
//
// One byte is taken per cycle while req_stall is low; a result is registered in the queue
// and then in the output register before it appears on rsp. Throughput is one beat per
// cycle while neither side stalls, set by the phase update in the front end. req_stall
// rises only when the two-entry queue is full, that is, when two results wait behind a
// stalled beat in the output register. Synchronous reset returns the parser to the type
// phase and empties the queue.
module type_length_frame_parser_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tlfp_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tlfp_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tlfp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tlfp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tlfp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import tlfp_pkg::*;

   logic [LEN_W-1:0]  max_len_ff, max_len_in;
   logic              csr_wr;
   logic              csr_hit;
   logic              accept;
   logic              push;
   logic              pop;
   rsp_type           push_data;
   rsp_type           head_data;
   queue_status_type  status;

   // Configuration register: only word index zero exists.
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_ADDR_W-1] == 1'b0;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign max_len_in = csr_wr ? csr_pwdata[LEN_W-1:0] : max_len_ff;
   assign csr_prdata = csr_hit ? {{(CSR_DATA_W-LEN_W){1'b0}}, max_len_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_PAYLOAD_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // Input handshake.
   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   tlfp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .req_data           (req_data),
      .max_payload_length (max_len_ff),
      .push               (push),
      .push_data          (push_data)
   );

   tlfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (status)
   );

   tlfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .head_data (head_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: test/tlfp_result_checker.sv
// Scoreboard for the type-length frame parser: watches the byte, result and CSR ports.
// Keeps its own parser state, predicts every result beat and compares it field by field.
// Depends on tlfp_pkg for the beat structs, result kinds, error codes and phases.
module tlfp_result_checker #(
   parameter logic [tlfp_pkg::CSR_ADDR_W-1:0] MAX_LEN_ADDR = '0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  tlfp_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  tlfp_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tlfp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tlfp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [tlfp_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                            csr_pready,
   output int                              error_count,
   output int                              results_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import tlfp_pkg::*;

   // Shadow copy of the parser state and the length limit.
   logic [LEN_W-1:0]  max_length   = MAX_PAYLOAD_RESET;
   phase_type         parse_phase  = PH_TYPE;
   logic [7:0]        frame_type_q = '0;
   logic [LEN_W-1:0]  length_sum   = '0;
   logic [LCNT_W-1:0] length_bytes = '0;
   logic [LEN_W-1:0]  bytes_left   = '0;

   // Results predicted but not yet seen on the rsp port, oldest first.
   rsp_type expected_results[$];
   int      failures = 0;

   function automatic string result_text(input rsp_type r);
      return $sformatf("kind=%0d type=%02h len=%0d byte=%02h err=%0d end=%0d",
                       r.result_kind, r.frame_type, r.frame_length, r.payload_byte,
                       r.error_code, r.frame_end);
   endfunction

   // Counts a failure and tells whether it is still among the ones worth printing.
   function automatic bit count_failure();
      failures++;
      return failures <= 10;
   endfunction

   task automatic queue_result(input logic [1:0] kind, input logic [LEN_W-1:0] len,
                               input logic [7:0] data, input logic [1:0] code,
                               input logic last);
      rsp_type r;
      r              = '0;
      r.result_kind  = kind;
      r.frame_type   = frame_type_q;
      r.frame_length = len;
      r.payload_byte = data;
      r.error_code   = code;
      r.frame_end    = last;
      expected_results.push_back(r);
   endtask

   // Advances the shadow parser by one received byte and queues the result it causes.
   task automatic parse_rx_byte(input req_type beat);
      if (beat.resync) begin
         parse_phase  = PH_TYPE;
         length_sum   = '0;
         length_bytes = '0;
         bytes_left   = '0;
      end
      case (parse_phase)
         PH_TYPE: begin
            frame_type_q = beat.rx_byte;
            length_sum   = '0;
            length_bytes = '0;
            if (beat.rx_byte == 8'h00) begin
               parse_phase = PH_ERROR;
               queue_result(KIND_ERROR, '0, '0, ERR_ZERO_TYPE, 1'b0);
            end else begin
               parse_phase = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            length_sum = length_sum | (LEN_W'(beat.rx_byte[6:0]) << (7 * length_bytes));
            if (beat.rx_byte[7]) begin
               // A continuation on the last allowed length byte can never complete.
               if (int'(length_bytes) + 1 >= MAX_LENGTH_BYTES) begin
                  parse_phase = PH_ERROR;
                  queue_result(KIND_ERROR, '0, '0, ERR_OVERLONG, 1'b0);
               end else begin
                  length_bytes = length_bytes + 1'b1;
               end
            end else if (length_sum > max_length) begin
               parse_phase = PH_ERROR;
               queue_result(KIND_ERROR, '0, '0, ERR_TOO_LONG, 1'b0);
            end else if (length_sum == '0) begin
               // An empty frame ends on its header.
               parse_phase = PH_TYPE;
               queue_result(KIND_HEADER, '0, '0, ERR_NONE, 1'b1);
            end else begin
               bytes_left  = length_sum;
               parse_phase = PH_PAYLOAD;
               queue_result(KIND_HEADER, length_sum, '0, ERR_NONE, 1'b0);
            end
         end
         PH_PAYLOAD: begin
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == '0) begin
               parse_phase = PH_TYPE;
            end
            queue_result(KIND_PAYLOAD, '0, beat.rx_byte, ERR_NONE, bytes_left == '0);
         end
         default: begin
            // Silent until a resync arrives.
         end
      endcase
   endtask

   // Per-edge bookkeeping: CSR accesses, byte beats, result beats.
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         max_length   = MAX_PAYLOAD_RESET;
         parse_phase  = PH_TYPE;
         frame_type_q = '0;
         length_sum   = '0;
         length_bytes = '0;
         bytes_left   = '0;
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == MAX_LEN_ADDR) begin
            if (csr_pwrite) begin
               max_length = csr_pwdata[LEN_W-1:0];
            end else if (csr_prdata[LEN_W-1:0] !== max_length) begin
               if (count_failure())
                  $display("%0t: max_payload_length reads %0d, expected %0d",
                           $realtime, csr_prdata[LEN_W-1:0], max_length);
            end
         end
         if (req_valid && !req_stall) begin
            parse_rx_byte(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               if (count_failure())
                  $display("%0t: unexpected result %s", $realtime, result_text(rsp_data));
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.result_kind !== want.result_kind ||
                   rsp_data.frame_type !== want.frame_type ||
                   rsp_data.frame_length !== want.frame_length ||
                   rsp_data.payload_byte !== want.payload_byte ||
                   rsp_data.error_code !== want.error_code ||
                   rsp_data.frame_end !== want.frame_end) begin
                  if (count_failure())
                     $display("%0t: result mismatch\n   expected %s\n   actual   %s",
                              $realtime, result_text(want), result_text(rsp_data));
               end
            end
         end
      end
      error_count <= failures;
      results_due <= expected_results.size();
   end

endmodule

FILE: test/tb_type_length_frame_parser_unit.sv
// Top-level bench for type_length_frame_parser_unit: clock, reset, byte and CSR stimulus.
// Depends on tlfp_pkg, the parser RTL and tlfp_result_checker, which does all checking.
module tb_type_length_frame_parser_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import tlfp_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] MAX_LEN_ADDR     = '0;
   localparam logic [LEN_W-1:0]      LEN_MAX          = '1;
   localparam int                    WATCHDOG_LIMIT   = 4000;
   localparam int                    LONG_HOLD_CYCLES = 80;
   localparam int                    DRAIN_CYCLES     = 4;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    error_count;
   int                    results_due;

   int               tx_idle_pct    = 32;
   int               rx_idle_pct    = 75;
   int               holds_asked    = 0;
   int               holds_served   = 0;
   int               hold_left      = 0;
   int               quiet_cycles   = 0;
   int               beats_counted  = 0;
   logic [LEN_W-1:0] max_length_set = MAX_PAYLOAD_RESET;
   bit               need_resync    = 1'b0;

   type_length_frame_parser_unit u_top (.*);

   tlfp_result_checker #(.MAX_LEN_ADDR(MAX_LEN_ADDR)) u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: random stall, or a long hold-off when the stimulus asks for one.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_stall    <= 1'b1;
         hold_left    <= LONG_HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Watchdog: too long without any beat or CSR access means the run is stuck.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_type_length_frame_parser_unit: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one byte beat, with random idle cycles first, and waits until it is taken.
   task automatic send_beat(input logic [7:0] data, input logic resync, input bit counts);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{rx_byte: data, resync: resync};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (counts) beats_counted++;
   endtask

   task automatic send_type(input logic [7:0] data);
      send_beat(data, need_resync || ($urandom_range(7) == 0), 1'b1);
      need_resync = 1'b0;
   endtask

   // Base-128 length, shortest form or padded with continuation bytes up to four.
   task automatic send_length(input logic [LEN_W-1:0] len);
      int nb;
      nb = (len < 28'd128) ? 1 : (len < 28'd16384) ? 2 : (len < 28'd2097152) ? 3 : 4;
      if ($urandom_range(3) == 0) nb = $urandom_range(4, nb);
      for (int i = 0; i < nb; i++)
         send_beat({i < nb - 1, 7'(len >> (7 * i))}, 1'b0, 1'b1);
   endtask

   task automatic send_payload(input int count);
      repeat (count) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   // After an error the parser ignores bytes; sometimes feed it a little noise.
   task automatic after_error();
      need_resync = 1'b1;
      if ($urandom_range(1) == 0)
         repeat ($urandom_range(3, 1)) send_beat(8'($urandom), 1'b0, 1'b0);
   endtask

   // One random frame: mostly well formed, the rest malformed or cut short.
   task automatic send_random_frame();
      int               pick;
      int               n;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] cap;
      pick = $urandom_range(99);
      cap  = (max_length_set < 28'd24) ? max_length_set : 28'd24;
      if (pick >= 76 && pick < 84 && max_length_set == LEN_MAX) pick = 0;
      if (pick < 60) begin
         if (max_length_set <= 28'd300 && $urandom_range(9) == 0)
            len = max_length_set;
         else
            len = $urandom_range(cap, 0);
         send_type(8'($urandom_range(255, 1)));
         send_length(len);
         send_payload(int'(len));
      end else if (pick < 68) begin
         send_beat(8'h00, need_resync || ($urandom_range(1) == 0), 1'b1);
         need_resync = 1'b0;
         after_error();
      end else if (pick < 76) begin
         send_type(8'($urandom_range(255, 1)));
         repeat (4) send_beat(8'h80 | 8'($urandom_range(127)), 1'b0, 1'b1);
         after_error();
      end else if (pick < 84) begin
         if ($urandom_range(1) == 0)
            len = max_length_set + 1'b1;
         else
            len = $urandom_range(LEN_MAX, max_length_set + 1'b1);
         send_type(8'($urandom_range(255, 1)));
         send_length(len);
         after_error();
      end else begin
         send_type(8'($urandom_range(255, 1)));
         if (max_length_set < 28'd2 || $urandom_range(2) == 0) begin
            // Cut off inside the length field.
            repeat ($urandom_range(3, 1)) send_beat(8'h80 | 8'($urandom_range(127)), 1'b0, 1'b1);
         end else begin
            if (max_length_set > 28'd64 && $urandom_range(1) == 0)
               len = $urandom_range(max_length_set, 64);
            else
               len = $urandom_range(cap, 2);
            send_length(len);
            n = int'(len) - 1;
            if (n > 6) n = 6;
            send_payload($urandom_range(n, 0));
         end
         need_resync = 1'b1;
      end
   endtask

   task automatic run_random(input int count);
      beats_counted = 0;
      while (beats_counted < count) send_random_frame();
   endtask

   // Stops offering bytes and waits until every predicted result has come out.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= MAX_LEN_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Limit changes only while the parser is idle; read back to check the register.
   task automatic write_max_length(input logic [LEN_W-1:0] value);
      drain();
      csr_access(1'b1, CSR_DATA_W'(value));
      csr_access(1'b0, '0);
      max_length_set = value;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under the reset limit.
      // Zero type right after reset, then a byte the error phase must ignore.
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'h5A, 1'b0, 1'b0);
      // Resync into an empty frame with the highest type.
      send_beat(8'hFF, 1'b1, 1'b1);
      send_beat(8'h00, 1'b0, 1'b1);
      // Largest encodable length, far over the limit.
      send_beat(8'h80, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b0, 1'b1);
      send_beat(8'h7F, 1'b0, 1'b1);
      // Continuation on the fourth length byte.
      send_beat(8'h42, 1'b1, 1'b1);
      repeat (4) send_beat(8'h80, 1'b0, 1'b1);
      // Short frame with extreme payload bytes.
      send_beat(8'h7E, 1'b1, 1'b1);
      send_beat(8'h02, 1'b0, 1'b1);
      send_beat(8'hFF, 1'b0, 1'b1);
      send_beat(8'h00, 1'b0, 1'b1);
      // Four-byte length exactly at the limit, cut short by a resync.
      send_beat(8'h01, 1'b0, 1'b1);
      send_beat(8'h80, 1'b0, 1'b1);
      send_beat(8'h80, 1'b0, 1'b1);
      send_beat(8'h80, 1'b0, 1'b1);
      send_beat(8'h02, 1'b0, 1'b1);
      send_beat(8'hA5, 1'b0, 1'b1);
      send_beat(8'h33, 1'b1, 1'b1);
      send_beat(8'h01, 1'b0, 1'b1);
      send_beat(8'h00, 1'b0, 1'b1);

      // Random frames, sender idling lightly and receiver heavily.
      write_max_length(LEN_MAX);
      holds_asked <= holds_asked + 1;
      run_random(200);
      write_max_length('0);
      run_random(120);

      // Sender idling heavily, receiver lightly.
      tx_idle_pct <= 75;
      rx_idle_pct <= 32;
      write_max_length(28'd30);
      run_random(200);
      write_max_length(28'($urandom_range(5000, 1)));
      run_random(180);

      // Full rate on both sides, with one long hold-off to back the block up.
      tx_idle_pct <= 0;
      rx_idle_pct <= 0;
      write_max_length(MAX_PAYLOAD_RESET);
      holds_asked <= holds_asked + 1;
      run_random(180);

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && results_due == 0) begin
         $display("tb_type_length_frame_parser_unit: done, clean");
      end else begin
         $display("tb_type_length_frame_parser_unit: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/tlfp_pkg.sv
sv/tlfp_front.sv
sv/tlfp_queue.sv
sv/tlfp_back.sv
sv/type_length_frame_parser_unit.sv
test/tlfp_result_checker.sv
test/tb_type_length_frame_parser_unit.sv
